// File: rtl/core/fcv_pkg.sv
// ----------------------------------------------------------------------------
// fcv_pkg: shared types and constants of the camera view update block
// Holds the sequencer states, the multiply operations, the register
// indexes, the arctangent table and the saturation helpers.
// ----------------------------------------------------------------------------
package fcv_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FULL_TURN        = 92160;
   localparam int PITCH_MAX        = 23040;
   localparam int CORDIC_GAIN      = 652032874;
   localparam int Q14_ONE          = 16384;

   localparam logic [15:0] SENS_RESET = 16'd128;
   localparam logic [14:0] PLIM_RESET = 15'd22784;

   typedef enum logic [0:0] {
      CSR_SENSITIVITY = 1'b0,
      CSR_PITCH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_POST,
      S_MOD,
      S_DIV,
      S_CINIT,
      S_CORDIC,
      S_TPOST,
      S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_MX0, OP_MX1, OP_MZ0, OP_MZ1, OP_DYAW, OP_DPITCH,
      OP_FX, OP_FZ, OP_UX, OP_UZ,
      OP_TX0, OP_TX1, OP_TY0, OP_TY1, OP_TY2, OP_TZ0, OP_TZ1, OP_TZ2
   } op_type;

   typedef struct packed {
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] upv_x;
      logic signed [15:0] upv_y;
      logic signed [15:0] upv_z;
      logic signed [15:0] back_x;
      logic signed [15:0] back_y;
      logic signed [15:0] back_z;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
   } rsp_word_type;

   // An operation that starts a new sum rather than adding to the last one.
   function automatic logic op_first(input op_type op);
      case (op) inside
         OP_MX0, OP_MZ0, OP_DYAW, OP_DPITCH, OP_FX, OP_FZ, OP_UX, OP_UZ,
         OP_TX0, OP_TY0, OP_TZ0: return 1'b1;
         default:                return 1'b0;
      endcase
   endfunction

   function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
      case (idx)
         5'd0:  return 32'd536870912;
         5'd1:  return 32'd316933406;
         5'd2:  return 32'd167458907;
         5'd3:  return 32'd85004756;
         5'd4:  return 32'd42667331;
         5'd5:  return 32'd21354465;
         5'd6:  return 32'd10679838;
         5'd7:  return 32'd5340245;
         5'd8:  return 32'd2670163;
         5'd9:  return 32'd1335087;
         5'd10: return 32'd667544;
         5'd11: return 32'd333772;
         5'd12: return 32'd166886;
         5'd13: return 32'd83443;
         5'd14: return 32'd41722;
         5'd15: return 32'd20861;
         5'd16: return 32'd10430;
         5'd17: return 32'd5215;
         5'd18: return 32'd2608;
         5'd19: return 32'd1304;
         5'd20: return 32'd652;
         5'd21: return 32'd326;
         5'd22: return 32'd163;
         5'd23: return 32'd81;
         default: return 32'd0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      if (v > 38'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -38'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
      if (v == 32'sh8000_0000) begin
         return 32'h7FFF_FFFF;
      end
      return -v;
   endfunction

   function automatic logic signed [15:0] clamp_q14(input logic signed [35:0] v);
      if (v > 36'sd16384) begin
         return 16'sd16384;
      end else if (v < -36'sd16384) begin
         return -16'sd16384;
      end
      return v[15:0];
   endfunction

endpackage

// File: rtl/core/fcv_req_if.sv
// ----------------------------------------------------------------------------
// fcv_req_if: input channel of the camera view update block
// Carries one word of mouse delta and relative move per frame.
// ----------------------------------------------------------------------------
interface fcv_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] mouse_dx;
   logic signed [15:0] mouse_dy;
   logic signed [31:0] move_side;
   logic signed [31:0] move_up;
   logic signed [31:0] move_forward;

   modport source (output valid, mouse_dx, mouse_dy, move_side, move_up, move_forward,
                   input ready);
   modport sink (input valid, mouse_dx, mouse_dy, move_side, move_up, move_forward,
                 output ready);
endinterface

// File: rtl/core/fcv_rsp_if.sv
// ----------------------------------------------------------------------------
// fcv_rsp_if: result channel of the camera view update block
// Carries the three view matrix rows and the translation column.
// ----------------------------------------------------------------------------
interface fcv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] right_x;
   logic signed [15:0] right_y;
   logic signed [15:0] right_z;
   logic signed [15:0] upv_x;
   logic signed [15:0] upv_y;
   logic signed [15:0] upv_z;
   logic signed [15:0] back_x;
   logic signed [15:0] back_y;
   logic signed [15:0] back_z;
   logic signed [31:0] trans_x;
   logic signed [31:0] trans_y;
   logic signed [31:0] trans_z;

   modport source (output valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
                   back_x, back_y, back_z, trans_x, trans_y, trans_z, input ready);
   modport sink (input valid, right_x, right_y, right_z, upv_x, upv_y, upv_z,
                 back_x, back_y, back_z, trans_x, trans_y, trans_z, output ready);
endinterface

// File: rtl/core/fps_camera_view_update.sv
// ----------------------------------------------------------------------------
// fps_camera_view_update: first-person camera view matrix update
// Moves the camera, turns yaw and pitch, and builds the lookAt view rows.
// ----------------------------------------------------------------------------
// Usage: each word on req_if (mouse delta and relative move) yields exactly
// one word on rsp_if (right, up and back rows in Q2.14, translation in
// Q16.16). The user writes sensitivity and pitch limit on the csr_ port only
// while the block is idle; the block itself does not enforce this. A word is
// worked through in steps: eighteen products run through one bit-serial
// multiplier, each followed by a rounding step, the yaw is wrapped, and each
// of the two sine/cosine evaluations needs a bit-serial division to the binary
// angle, a setup step, CORDIC_STEPS (default 16) rotation steps and a step to
// fold the quadrant. A new word is taken only once the last one is through the
// sequencer. req_if.ready is high only while the sequencer is idle; a
// finished word waits in the output register, so the next word is taken
// while the receiver stalls, and its result waits for the output register to
// free. Reset clears position, yaw and pitch, loads the default registers and
// drops rsp_if.valid.
// ----------------------------------------------------------------------------
module fps_camera_view_update #(
   parameter int CORDIC_STEPS = fcv_pkg::CORDIC_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   fcv_req_if.sink                req_if,
   fcv_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  fcv_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata
);
   import fcv_pkg::*;

   localparam logic [5:0] MUL_LAST = 6'd16;
   localparam logic [5:0] MOD_LAST = 6'd7;
   localparam logic [5:0] DIV_LAST = 6'd40;
   localparam logic [5:0] COR_LAST = 6'(CORDIC_STEPS - 1);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       trig_pitch_ff, trig_pitch_in;

   logic signed [15:0] dx_ff, dy_ff;
   logic signed [31:0] ms_ff, mu_ff, mf_ff;
   logic [15:0] sens_ff, sens_in;
   logic [14:0] plim_ff, plim_in;

   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic [16:0]        yaw_ff, yaw_in;
   logic signed [15:0] pitch_ff, pitch_in;
   logic signed [15:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;
   logic signed [15:0] fx_ff, fx_in, fz_ff, fz_in, ux_ff, ux_in, uz_ff, uz_in;
   logic signed [31:0] tx_ff, tx_in, ty_ff, ty_in, tz_ff, tz_in;

   logic signed [49:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [16:0]        mplier_ff, mplier_in;
   logic [24:0]        v_ff, v_in;
   logic [40:0]        dvd_ff, dvd_in;
   logic [8:0]         rem_ff, rem_in;
   logic [31:0]        qt_ff, qt_in;
   logic signed [33:0] cor_x_ff, cor_x_in, cor_y_ff, cor_y_in, cor_z_ff, cor_z_in;
   logic [1:0]         quad_ff, quad_in;

   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic accept, out_load;

   // Datapath helpers.
   logic signed [31:0] sel_a;
   logic signed [16:0] sel_b;
   logic signed [49:0] cur_a, term, base, rsum, dsum;
   logic [16:0]        cur_b;
   logic               neg;
   logic signed [35:0] rnd14;
   logic signed [25:0] d26;
   logic signed [15:0] q14v;
   logic signed [31:0] t32;
   logic signed [26:0] vsum, pnew, lim27;
   logic [14:0]        lim;
   logic [24:0]        mod_m, mod_r;
   logic [9:0]         r10;
   logic               ge;
   logic [31:0]        qsum, z32;
   logic [1:0]         qd;
   logic signed [33:0] xs, ys, at, xr, yr;
   logic signed [15:0] cc, ss, c_val, s_val;
   logic [17:0]        pang18;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);
   assign out_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_MUL;
         S_MUL:    if (cnt_ff == MUL_LAST) state_in = S_POST;
         S_POST: begin
            case (op_ff)
               OP_DYAW:   state_in = S_MOD;
               OP_DPITCH: state_in = S_DIV;
               OP_TZ2:    state_in = S_DONE;
               default:   state_in = S_MUL;
            endcase
         end
         S_MOD:    if (cnt_ff == MOD_LAST) state_in = S_MUL;
         S_DIV:    if (cnt_ff == DIV_LAST) state_in = S_CINIT;
         S_CINIT:  state_in = S_CORDIC;
         S_CORDIC: if (cnt_ff == COR_LAST) state_in = S_TPOST;
         S_TPOST:  state_in = trig_pitch_ff ? S_MUL : S_DIV;
         S_DONE:   if (out_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Operand selection for the serial multiplier.
   always_comb begin
      case (op_ff)
         OP_MX0:    begin sel_a = mf_ff; sel_b = 17'(cy_ff); end
         OP_MX1:    begin sel_a = ms_ff; sel_b = 17'(sy_ff); end
         OP_MZ0:    begin sel_a = mf_ff; sel_b = 17'(sy_ff); end
         OP_MZ1:    begin sel_a = ms_ff; sel_b = 17'(cy_ff); end
         OP_DYAW:   begin sel_a = 32'(dx_ff); sel_b = {1'b0, sens_ff}; end
         OP_DPITCH: begin sel_a = 32'(dy_ff); sel_b = {1'b0, sens_ff}; end
         OP_FX:     begin sel_a = 32'(cy_ff); sel_b = 17'(cp_ff); end
         OP_FZ:     begin sel_a = 32'(sy_ff); sel_b = 17'(cp_ff); end
         OP_UX:     begin sel_a = 32'(cy_ff); sel_b = 17'(sp_ff); end
         OP_UZ:     begin sel_a = 32'(sy_ff); sel_b = 17'(sp_ff); end
         OP_TX0:    begin sel_a = pos_x_ff; sel_b = -17'(sy_ff); end
         OP_TX1:    begin sel_a = pos_z_ff; sel_b = 17'(cy_ff); end
         OP_TY0:    begin sel_a = pos_x_ff; sel_b = 17'(ux_ff); end
         OP_TY1:    begin sel_a = pos_y_ff; sel_b = 17'(cp_ff); end
         OP_TY2:    begin sel_a = pos_z_ff; sel_b = 17'(uz_ff); end
         OP_TZ0:    begin sel_a = pos_x_ff; sel_b = 17'(fx_ff); end
         OP_TZ1:    begin sel_a = pos_y_ff; sel_b = 17'(sp_ff); end
         OP_TZ2:    begin sel_a = pos_z_ff; sel_b = 17'(fz_ff); end
         default:   begin sel_a = '0; sel_b = '0; end
      endcase
   end

   // Shared arithmetic terms.
   always_comb begin
      cur_a = (cnt_ff == '0) ? 50'(sel_a) : mcand_ff;
      cur_b = (cnt_ff == '0) ? sel_b : mplier_ff;
      term  = cur_b[0] ? cur_a : '0;
      // The top multiplier bit carries negative weight; OP_MX1 subtracts its product.
      neg   = (cnt_ff == MUL_LAST) ^ (op_ff == OP_MX1);
      base  = ((cnt_ff == '0) && op_first(op_ff)) ? '0 : acc_ff;

      rsum  = acc_ff + 50'sd8192;
      rnd14 = rsum[49:14];
      dsum  = acc_ff + 50'sd128;
      d26   = dsum[33:8];
      q14v  = clamp_q14(rnd14);
      t32   = sat32(38'(rnd14));

      vsum  = 27'(yaw_ff) + 27'(d26) + 27'sd11796480;
      pnew  = 27'(pitch_ff) - 27'(d26);
      lim   = (plim_ff > 15'(PITCH_MAX)) ? 15'(PITCH_MAX) : plim_ff;
      lim27 = 27'(lim);

      mod_m = 25'(FULL_TURN) << (3'd7 - cnt_ff[2:0]);
      mod_r = (v_ff >= mod_m) ? v_ff - mod_m : v_ff;

      r10   = {rem_ff, dvd_ff[40]};
      ge    = (r10 >= 10'd360);

      qsum  = qt_ff + 32'h2000_0000;
      qd    = qsum[31:30];
      z32   = qt_ff - {qd, 30'd0};

      xs    = cor_x_ff >>> cnt_ff;
      ys    = cor_y_ff >>> cnt_ff;
      at    = 34'(atan_lookup(5'(cnt_ff)));

      xr    = cor_x_ff + 34'sd32768;
      yr    = cor_y_ff + 34'sd32768;
      cc    = clamp_q14(36'(signed'(xr[33:16])));
      ss    = clamp_q14(36'(signed'(yr[33:16])));
      case (quad_ff)
         2'd1:    begin c_val = -ss; s_val = cc; end
         2'd2:    begin c_val = -cc; s_val = -ss; end
         2'd3:    begin c_val = ss;  s_val = -cc; end
         default: begin c_val = cc;  s_val = ss; end
      endcase
      pang18 = pitch_ff[15] ? 18'(pitch_ff) + 18'd92160 : 18'(pitch_ff);
   end

   // Register updates per state.
   always_comb begin
      op_in         = op_ff;
      cnt_in        = (state_in != state_ff || state_ff == S_IDLE) ? '0 : cnt_ff + 6'd1;
      trig_pitch_in = trig_pitch_ff;
      sens_in       = sens_ff;
      plim_in       = plim_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      pos_z_in      = pos_z_ff;
      yaw_in        = yaw_ff;
      pitch_in      = pitch_ff;
      cy_in         = cy_ff;
      sy_in         = sy_ff;
      cp_in         = cp_ff;
      sp_in         = sp_ff;
      fx_in         = fx_ff;
      fz_in         = fz_ff;
      ux_in         = ux_ff;
      uz_in         = uz_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      tz_in         = tz_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      v_in          = v_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      qt_in         = qt_ff;
      cor_x_in      = cor_x_ff;
      cor_y_in      = cor_y_ff;
      cor_z_in      = cor_z_ff;
      quad_in       = quad_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = (rsp_valid_ff && rsp_if.ready) ? 1'b0 : rsp_valid_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SENSITIVITY: sens_in = csr_wdata;
            CSR_PITCH_LIMIT: plim_in = csr_wdata[14:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) op_in = OP_MX0;
         end
         S_MUL: begin
            acc_in    = neg ? base - term : base + term;
            mcand_in  = cur_a <<< 1;
            mplier_in = cur_b >> 1;
         end
         S_POST: begin
            if (op_ff != OP_TZ2) op_in = op_type'(op_ff + 5'd1);
            case (op_ff)
               OP_MX1: pos_x_in = sat32(38'(pos_x_ff) + 38'(rnd14));
               OP_MZ1: begin
                  pos_z_in = sat32(38'(pos_z_ff) + 38'(rnd14));
                  pos_y_in = sat32(38'(pos_y_ff) + 38'(mu_ff));
               end
               OP_DYAW: v_in = vsum[24:0];
               OP_DPITCH: begin
                  if (pnew > lim27) begin
                     pitch_in = 16'(lim27);
                  end else if (pnew < -lim27) begin
                     pitch_in = 16'(-lim27);
                  end else begin
                     pitch_in = pnew[15:0];
                  end
                  dvd_in        = {yaw_ff, 24'd180};
                  rem_in        = '0;
                  trig_pitch_in = 1'b0;
               end
               OP_FX:  fx_in = q14v;
               OP_FZ:  fz_in = q14v;
               OP_UX:  ux_in = -q14v;
               OP_UZ:  uz_in = -q14v;
               OP_TX1: tx_in = neg_sat32(t32);
               OP_TY2: ty_in = neg_sat32(t32);
               OP_TZ2: tz_in = t32;
               default: ;
            endcase
         end
         S_MOD: begin
            v_in = mod_r;
            if (cnt_ff == MOD_LAST) yaw_in = mod_r[16:0];
         end
         S_DIV: begin
            rem_in = ge ? 9'(r10 - 10'd360) : r10[8:0];
            qt_in  = {qt_ff[30:0], ge};
            dvd_in = dvd_ff << 1;
         end
         S_CINIT: begin
            cor_x_in = 34'sd652032874;
            cor_y_in = '0;
            cor_z_in = 34'(signed'(z32));
            quad_in  = qd;
         end
         S_CORDIC: begin
            if (!cor_z_ff[33]) begin
               cor_x_in = cor_x_ff - ys;
               cor_y_in = cor_y_ff + xs;
               cor_z_in = cor_z_ff - at;
            end else begin
               cor_x_in = cor_x_ff + ys;
               cor_y_in = cor_y_ff - xs;
               cor_z_in = cor_z_ff + at;
            end
         end
         S_TPOST: begin
            if (!trig_pitch_ff) begin
               cy_in         = c_val;
               sy_in         = s_val;
               dvd_in        = {pang18[16:0], 24'd180};
               rem_in        = '0;
               trig_pitch_in = 1'b1;
            end else begin
               cp_in = c_val;
               sp_in = s_val;
            end
         end
         S_DONE: begin
            if (out_load) begin
               rsp_in.right_x = -sy_ff;
               rsp_in.right_y = '0;
               rsp_in.right_z = cy_ff;
               rsp_in.upv_x   = ux_ff;
               rsp_in.upv_y   = cp_ff;
               rsp_in.upv_z   = uz_ff;
               rsp_in.back_x  = -fx_ff;
               rsp_in.back_y  = -sp_ff;
               rsp_in.back_z  = -fz_ff;
               rsp_in.trans_x = tx_ff;
               rsp_in.trans_y = ty_ff;
               rsp_in.trans_z = tz_ff;
               rsp_valid_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_MX0;
         cnt_ff        <= '0;
         trig_pitch_ff <= 1'b0;
         sens_ff       <= SENS_RESET;
         plim_ff       <= PLIM_RESET;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         pos_z_ff      <= '0;
         yaw_ff        <= '0;
         pitch_ff      <= '0;
         cy_ff         <= 16'(Q14_ONE);
         sy_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         cnt_ff        <= cnt_in;
         trig_pitch_ff <= trig_pitch_in;
         sens_ff       <= sens_in;
         plim_ff       <= plim_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         pos_z_ff      <= pos_z_in;
         yaw_ff        <= yaw_in;
         pitch_ff      <= pitch_in;
         cy_ff         <= cy_in;
         sy_ff         <= sy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff <= req_if.mouse_dx;
         dy_ff <= req_if.mouse_dy;
         ms_ff <= req_if.move_side;
         mu_ff <= req_if.move_up;
         mf_ff <= req_if.move_forward;
      end
      cp_ff     <= cp_in;
      sp_ff     <= sp_in;
      fx_ff     <= fx_in;
      fz_ff     <= fz_in;
      ux_ff     <= ux_in;
      uz_ff     <= uz_in;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
      tz_ff     <= tz_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      v_ff      <= v_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      qt_ff     <= qt_in;
      cor_x_ff  <= cor_x_in;
      cor_y_ff  <= cor_y_in;
      cor_z_ff  <= cor_z_in;
      quad_ff   <= quad_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.right_x = rsp_ff.right_x;
   assign rsp_if.right_y = rsp_ff.right_y;
   assign rsp_if.right_z = rsp_ff.right_z;
   assign rsp_if.upv_x   = rsp_ff.upv_x;
   assign rsp_if.upv_y   = rsp_ff.upv_y;
   assign rsp_if.upv_z   = rsp_ff.upv_z;
   assign rsp_if.back_x  = rsp_ff.back_x;
   assign rsp_if.back_y  = rsp_ff.back_y;
   assign rsp_if.back_z  = rsp_ff.back_z;
   assign rsp_if.trans_x = rsp_ff.trans_x;
   assign rsp_if.trans_y = rsp_ff.trans_y;
   assign rsp_if.trans_z = rsp_ff.trans_z;

endmodule

// File: rtl/core/fcv_checker.sv
// ----------------------------------------------------------------------------
// fcv_checker: port-level checks of the camera view update block
// Watches both channels and flags ordering and range errors.
// ----------------------------------------------------------------------------
module fcv_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] right_x,
   input logic signed [15:0] right_y,
   input logic signed [31:0] trans_x
);
   import fcv_pkg::*;

   // A held result word stays valid and keeps its trans_x value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(trans_x))
      else $error("result word changed while stalled");

   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One word at a time: the sequencer is busy right after it takes a word.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // The right vector stays in the horizontal plane.
   a_flat_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> right_y == 16'sd0)
      else $error("right vector has a vertical part");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (right_x <= signed'(16'(Q14_ONE))) &&
                    (right_x >= -signed'(16'(Q14_ONE))))
      else $error("right vector out of range");

endmodule

bind fps_camera_view_update fcv_checker u_fcv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .right_x   (rsp_if.right_x),
   .right_y   (rsp_if.right_y),
   .trans_x   (rsp_if.trans_x)
);

// File: test/tb_fps_camera_view_update.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fps_camera_view_update: self-checking bench of the camera view update
// Feeds mouse and move words, predicts each view matrix word from a
// bit-accurate model of the camera state, and compares each result word;
// gaps and result-side stalls come at random outside the last, quiet phase.
// ----------------------------------------------------------------------------
module tb_fps_camera_view_update;
   import fcv_pkg::*;

   typedef struct packed {
      logic signed [15:0] mouse_dx;
      logic signed [15:0] mouse_dy;
      logic signed [31:0] move_side;
      logic signed [31:0] move_up;
      logic signed [31:0] move_forward;
   } move_word_type;

   localparam int  NUM_RANDOM = 1100;
   localparam int  CYCLE_LIMIT = 4000000;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [15:0] csr_wdata;

   fcv_req_if req_if ();
   fcv_rsp_if rsp_if ();

   fps_camera_view_update i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Camera state as the prediction tracks it.
   longint cam_x, cam_y, cam_z, cam_yaw, cam_pitch, cam_cos, cam_sin;
   longint cam_sens, cam_plim;

   move_word_type move_queue[$];
   rsp_word_type  view_queue[$];
   int            mismatch_count;
   int            cycle_count;
   bit            quiet_mode;
   int            send_gap;
   int            sink_stall;
   bit            req_taken;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint shift_down(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat_word(longint v);
      return clip(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic longint round_q14(longint q30);
      return clip(shift_down(q30 + 32768, 16), -16384, 16384);
   endfunction

   function automatic longint mul_q14(longint a, longint b);
      return clip(shift_down(a * b + 8192, 14), -16384, 16384);
   endfunction

   // CORDIC sine and cosine of an angle in 1/256 degree, Q2.14 results.
   task automatic trig(input longint angle, output longint c, output longint s);
      longint a, z, x, y, nx, cc, ss;
      longint unsigned bam;
      longint q;
      longint atans[16];
      atans = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861};
      a = angle % FULL_TURN;
      if (a < 0) a += FULL_TURN;
      bam = ((longint'(a) * 16777216 + 180) / 360) & 64'hFFFF_FFFF;
      q = ((bam + 64'h2000_0000) >> 30) & 3;
      z = (bam - (q << 30)) & 64'hFFFF_FFFF;
      if (z >= 64'sd2147483648) z -= 64'sd4294967296;
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - shift_down(y, i);
            y = y + shift_down(x, i);
            z -= atans[i];
         end else begin
            nx = x + shift_down(y, i);
            y = y - shift_down(x, i);
            z += atans[i];
         end
         x = nx;
      end
      cc = round_q14(x);
      ss = round_q14(y);
      case (q)
         1: begin c = -ss; s = cc; end
         2: begin c = -cc; s = -ss; end
         3: begin c = ss; s = -cc; end
         default: begin c = cc; s = ss; end
      endcase
   endtask

   function automatic longint project(longint a, longint b, longint c);
      return sat_word(shift_down(a * cam_x + b * cam_y + c * cam_z + 8192, 14));
   endfunction

   task automatic predict_view(input move_word_type w, output rsp_word_type v);
      longint mx, mz, d, lim, cy, sy, cp, sp, fx, fz, ux, uz;
      mx = cam_cos * w.move_forward - cam_sin * w.move_side;
      mz = cam_sin * w.move_forward + cam_cos * w.move_side;
      cam_x = sat_word(cam_x + shift_down(mx + 8192, 14));
      cam_y = sat_word(cam_y + longint'(w.move_up));
      cam_z = sat_word(cam_z + shift_down(mz + 8192, 14));
      d = shift_down(longint'(w.mouse_dx) * cam_sens + 128, 8);
      cam_yaw = (cam_yaw + d) % FULL_TURN;
      if (cam_yaw < 0) cam_yaw += FULL_TURN;
      d = shift_down(longint'(w.mouse_dy) * cam_sens + 128, 8);
      lim = cam_plim > PITCH_MAX ? PITCH_MAX : cam_plim;
      cam_pitch = clip(cam_pitch - d, -lim, lim);
      trig(cam_yaw, cy, sy);
      trig(cam_pitch, cp, sp);
      fx = mul_q14(cy, cp);
      fz = mul_q14(sy, cp);
      ux = -mul_q14(cy, sp);
      uz = -mul_q14(sy, sp);
      v.right_x = -sy;
      v.right_y = 0;
      v.right_z = cy;
      v.upv_x = ux;
      v.upv_y = cp;
      v.upv_z = uz;
      v.back_x = -fx;
      v.back_y = -sp;
      v.back_z = -fz;
      v.trans_x = sat_word(-project(-sy, 0, cy));
      v.trans_y = sat_word(-project(ux, cp, uz));
      v.trans_z = project(fx, sp, fz);
      cam_cos = cy;
      cam_sin = sy;
   endtask

   function automatic move_word_type random_move();
      move_word_type w;
      w.mouse_dx = $urandom;
      w.mouse_dy = $urandom;
      w.move_side = $urandom;
      w.move_up = $urandom;
      w.move_forward = $urandom;
      // Mostly modest deltas so the angles wander rather than jump.
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            w.mouse_dx = $signed(16'($urandom_range(0, 1023))) - 512;
            w.mouse_dy = $signed(16'($urandom_range(0, 1023))) - 512;
            w.move_side = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            w.move_up = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            w.move_forward = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         end
         default: begin
            w.mouse_dx = $signed(16'($urandom_range(0, 8191))) - 4096;
            w.mouse_dy = $signed(16'($urandom_range(0, 8191))) - 4096;
            w.move_side = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
            w.move_forward = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
         end
      endcase
      return w;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SENSITIVITY) cam_sens = val;
      else cam_plim = val & 16'h7FFF;
   endtask

   task automatic queue_move(input move_word_type w);
      rsp_word_type v;
      predict_view(w, v);
      move_queue.push_back(w);
      view_queue.push_back(v);
   endtask

   task automatic drain();
      while (move_queue.size() != 0 || view_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_word(input logic signed [15:0] dx, input logic signed [15:0] dy,
                             input logic signed [31:0] ms, input logic signed [31:0] mu,
                             input logic signed [31:0] mf);
      move_word_type w;
      w = '{dx, dy, ms, mu, mf};
      queue_move(w);
   endtask

   // Driver: presents queued words with random gaps; a word is held until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_taken <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
      end else if (move_queue.size() != 0 && send_gap == 0) begin
         req_if.valid <= 1'b1;
         req_taken <= 1'b0;
         {req_if.mouse_dx, req_if.mouse_dy, req_if.move_side, req_if.move_up,
          req_if.move_forward} <= move_queue[0];
      end else begin
         req_if.valid <= 1'b0;
         req_taken <= 1'b0;
         if (send_gap > 0) send_gap <= send_gap - 1;
         else if (!quiet_mode && $urandom_range(0, 5) == 0)
            send_gap <= $urandom_range(1, 13);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         void'(move_queue.pop_front());
         req_taken <= 1'b1;
         if (!quiet_mode && $urandom_range(0, 2) == 0)
            send_gap <= $urandom_range(1, 13);
      end
   end

   // Result side stall pattern.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         sink_stall <= 0;
      end else if (sink_stall > 0) begin
         rsp_if.ready <= 1'b0;
         sink_stall <= sink_stall - 1;
      end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
         rsp_if.ready <= 1'b0;
         sink_stall <= $urandom_range(0, 12);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: checks each accepted word against the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.right_x, rsp_if.right_y, rsp_if.right_z, rsp_if.upv_x,
                 rsp_if.upv_y, rsp_if.upv_z, rsp_if.back_x, rsp_if.back_y,
                 rsp_if.back_z, rsp_if.trans_x, rsp_if.trans_y, rsp_if.trans_z};
         if (view_queue.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("unexpected result word %p", got);
         end else begin
            want = view_queue.pop_front();
            if (got !== want) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("view mismatch:\n  expected %p\n  actual   %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      move_word_type w;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SENSITIVITY;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.mouse_dx = '0;
      req_if.mouse_dy = '0;
      req_if.move_side = '0;
      req_if.move_up = '0;
      req_if.move_forward = '0;
      rsp_if.ready = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      quiet_mode = 1'b0;
      send_gap = 0;
      req_taken = 1'b0;
      cam_x = 0; cam_y = 0; cam_z = 0;
      cam_yaw = 0; cam_pitch = 0;
      cam_cos = 16384; cam_sin = 0;
      cam_sens = SENS_RESET;
      cam_plim = PLIM_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words under the reset settings.
      queue_word(0, 0, 0, 0, 0);
      queue_word(16'sh7FFF, 16'sh7FFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      queue_word(16'sh7FFF, 16'sh7FFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      queue_word(-16'sh8000, -16'sh8000, -32'sh8000_0000, -32'sh8000_0000,
                 -32'sh8000_0000);
      queue_word(-16'sh8000, -16'sh8000, -32'sh8000_0000, -32'sh8000_0000,
                 -32'sh8000_0000);
      queue_word(-16'sh8000, -16'sh8000, -32'sh8000_0000, -32'sh8000_0000,
                 -32'sh8000_0000);
      queue_word(16'sd180, -16'sd256, 32'sd65536, -32'sd65536, 32'sd131072);
      queue_word(-16'sd1, 16'sd1, -32'sd1, 32'sd1, -32'sd1);
      drain();

      // Pitch limit past 90 degrees, high sensitivity: pitch pinned at the poles.
      write_reg(CSR_PITCH_LIMIT, 16'h7FFF);
      write_reg(CSR_SENSITIVITY, 16'hFFFF);
      queue_word(16'sd100, -16'sh7FFF, 32'sd65536, 0, 32'sd65536);
      queue_word(16'sd23, -16'sd100, 32'sd65536, 0, 32'sd65536);
      queue_word(16'sd47, 16'sh7FFF, -32'sd65536, 0, 32'sd65536);
      queue_word(16'sd90, 16'sd5, 32'sd999, 0, -32'sd777);
      drain();
      write_reg(CSR_PITCH_LIMIT, 16'd23040);
      write_reg(CSR_SENSITIVITY, 16'd256);
      queue_word(16'sd23040, -16'sd23040, 32'sd65536, 0, 32'sd65536);
      queue_word(16'sd23040, 16'sd30000, 32'sd65536, 0, 32'sd65536);
      drain();
      write_reg(CSR_PITCH_LIMIT, 16'd0);
      write_reg(CSR_SENSITIVITY, 16'd0);
      queue_word(16'sd500, 16'sd500, 32'sd12345, 32'sd54321, 32'sd99999);
      queue_word(-16'sd500, -16'sd500, -32'sd12345, 32'sd54321, 32'sd99999);
      drain();

      // Random phases through several settings.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(CSR_SENSITIVITY, SENS_RESET);
                     write_reg(CSR_PITCH_LIMIT, PLIM_RESET); end
            1: begin write_reg(CSR_SENSITIVITY, 16'($urandom_range(0, 65535)));
                     write_reg(CSR_PITCH_LIMIT, 16'($urandom_range(0, 32767))); end
            2: begin write_reg(CSR_SENSITIVITY, 16'hFFFF);
                     write_reg(CSR_PITCH_LIMIT, 16'd23040); end
            3: begin write_reg(CSR_SENSITIVITY, 16'd1);
                     write_reg(CSR_PITCH_LIMIT, 16'd0); end
            4: begin write_reg(CSR_SENSITIVITY, 16'($urandom_range(0, 1024)));
                     write_reg(CSR_PITCH_LIMIT, 16'($urandom_range(0, 23040))); end
            default: begin quiet_mode = 1'b1;
                     write_reg(CSR_SENSITIVITY, 16'd300);
                     write_reg(CSR_PITCH_LIMIT, 16'd20000); end
         endcase
         for (int k = 0; k < NUM_RANDOM / 6; k++) begin
            w = random_move();
            queue_move(w);
            while (move_queue.size() > 4) @(posedge clock);
         end
         drain();
      end
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
